>>> rtl/core/timed_speed_estimator_unit_macros.svh
// Assertion macros used by the speed estimator top level.
`ifndef TIMED_SPEED_ESTIMATOR_UNIT_MACROS_SVH
`define TIMED_SPEED_ESTIMATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks that a condition holds at every clock edge outside reset.
`define TSE_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// Checks that the consequent holds in the same cycle as the antecedent.
`define TSE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define TSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TSE_ASSERT_ALWAYS(label, expr)
`define TSE_ASSERT_IMPL(label, ante, cons)
`define TSE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/tse_pkg.sv
// Types and constants shared by the speed estimator modules.
package tse_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] STALE_LIMIT_RESET = 16'd300;
  // Doubled position difference: 33-bit difference shifted left once.
  localparam int NUM_W = 34;
  localparam int DT_W = 32;

  typedef struct packed {
    logic [31:0]        time_tick;
    logic signed [31:0] position;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] speed;
    logic               stale;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/tse_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tse_div
  import tse_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DT_W-1:0]  divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DT_W-1:0]  rem;
  logic [DT_W-1:0]  dvs;
  logic [NUM_W-1:0] dvd;
  logic [DT_W:0]    rem_sh;
  logic [DT_W:0]    rem_sub;
  logic             ge;

  assign rem_sh  = {rem, dvd[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend register shifts out from the top while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      dvd <= dividend;
    end else if (busy) begin
      rem <= ge ? rem_sub[DT_W-1:0] : rem_sh[DT_W-1:0];
      dvd <= {dvd[NUM_W-2:0], ge};
    end
  end

  assign quotient = dvd;

endmodule

>>> rtl/core/timed_speed_estimator_unit.sv
// Top level of the finite-difference speed estimator with stale timeout.
// One sample is in work at a time: a new timestamp goes through the 34-step
// bit-serial divider, a repeated timestamp skips it, and the next sample is
// accepted only after the result has been loaded into the output register.
// Reset (rst, synchronous, active high) clears the stored time, position,
// speed and idle counter, and loads stale_limit with 300.
`include "timed_speed_estimator_unit_macros.svh"

module timed_speed_estimator_unit
  import tse_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  sample_t            sample,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  // Width used to compare the idle counter against the stale limit.
  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  state_t state, state_next;

  // Architectural state.
  logic [LIMIT_W-1:0]     stale_limit;
  logic [31:0]            prev_time;
  logic signed [31:0]     prev_position;
  logic signed [31:0]     held_speed;
  logic [COUNT_WIDTH-1:0] idle_calls;

  // Per-item working registers, loaded when the item is accepted (the sign flag neg in the setup state).
  logic [31:0]            cur_time;
  logic signed [31:0]     cur_position;
  logic                   new_ts;
  logic [DT_W-1:0]        dt;
  logic [NUM_W-1:0]       num;
  logic                   neg;
  logic [COUNT_WIDTH-1:0] idle_inc;

  logic                   sample_take;
  logic                   result_load;
  logic                   div_start;
  logic                   div_done;
  logic [NUM_W-1:0]       div_quot;
  logic [NUM_W-1:0]       mag;
  logic [32:0]            pos_diff;
  logic signed [31:0]     sat_speed;
  logic                   stale_now;

  // The configuration register is always writable; the user must keep the block idle then (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_LIMIT_RESET;
    end else if (cfg_valid) begin
      stale_limit <= cfg_data;
    end
  end

  // Sequencer: accept, set up the divide (skipped for a repeated timestamp), wait for it, then hand over the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    div_start    = 1'b0;
    result_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        // A repeated timestamp needs no divide at all.
        if (new_ts) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // The output register frees up either empty or being taken this cycle.
        if (!result_valid || result_ready) begin
          result_load = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign sample_take = sample_valid && sample_ready;

  // Position difference is formed one bit wider so it cannot overflow; the gain of
  // two is a left shift.
  assign pos_diff = {sample.position[31], sample.position}
                  - {prev_position[31], prev_position};

  always_ff @(posedge clk) begin
    if (sample_take) begin
      cur_time     <= sample.time_tick;
      cur_position <= sample.position;
      new_ts       <= sample.time_tick != prev_time;
      dt           <= sample.time_tick - prev_time;
      num          <= {pos_diff, 1'b0};
      idle_inc     <= (&idle_calls) ? idle_calls : idle_calls + 1'b1;
    end
    if (state == S_SETUP) begin
      neg <= num[NUM_W-1];
    end
  end

  // The divider works on magnitudes; the sign is put back at the end, which gives
  // truncation toward zero.
  assign mag = num[NUM_W-1] ? (~num + 1'b1) : num;

  tse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (dt),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Saturate the signed quotient to 32 bits.
  always_comb begin
    if (!neg) begin
      sat_speed = (div_quot[NUM_W-1:31] != '0) ? 32'sh7FFF_FFFF
                                                : $signed(div_quot[31:0]);
    end else if ((div_quot[NUM_W-1:32] != '0)
                 || (div_quot[31] && (div_quot[30:0] != '0))) begin
      sat_speed = 32'sh8000_0000;
    end else begin
      sat_speed = $signed(~div_quot[31:0] + 32'd1);
    end
  end

  // A new timestamp clears the counter, so the timeout can only fire on a repeat.
  assign stale_now = !new_ts && (CMP_W'(idle_inc) > CMP_W'(stale_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time     <= '0;
      prev_position <= '0;
      held_speed    <= '0;
      idle_calls    <= '0;
    end else if (result_load) begin
      if (new_ts) begin
        prev_time     <= cur_time;
        prev_position <= cur_position;
        held_speed    <= sat_speed;
        idle_calls    <= '0;
      end else begin
        idle_calls <= idle_inc;
        if (stale_now) begin
          held_speed <= '0;
        end
      end
    end
  end

  // Output register: holds a finished item while the next one is already in work.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.stale <= stale_now;
      if (new_ts) begin
        result.speed <= sat_speed;
      end else if (stale_now) begin
        result.speed <= '0;
      end else begin
        result.speed <= held_speed;
      end
    end
  end

  // The divider may only finish while the sequencer waits for it.
  `TSE_ASSERT_IMPL(a_done_in_div, div_done, state == S_DIV)
  // A timed-out item always reports zero speed.
  `TSE_ASSERT_IMPL(a_stale_zero, result_valid && result.stale, result.speed == 0)
  // Only one item is in work at a time.
  `TSE_ASSERT_NEXT(a_one_item, sample_take, !sample_ready)

endmodule

>>> verif/tse_checker.sv
// Checker that predicts and compares the speed estimator's result items.
`timescale 1ns / 1ps

module tse_checker
  import tse_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  logic               sample_ready,
  input  sample_t            sample,
  input  logic               result_valid,
  input  logic               result_ready,
  input  result_t            result,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  output int                 errors,
  output int                 pending
);

  localparam longint unsigned CALLS_MAX = (64'd1 << COUNT_WIDTH) - 1;
  localparam longint SPEED_MAX = 64'sh7fffffff;
  localparam longint SPEED_MIN = -64'sh80000000;

  logic [LIMIT_W-1:0] limit_copy;
  logic [31:0]        last_tick;
  logic signed [31:0] last_pos;
  logic signed [31:0] speed_hold;
  longint unsigned    calls_since;
  result_t            speed_queue[$];
  int                 fail_count = 0;

  // Advances the predicted state by one sample and returns the result it gives.
  function automatic result_t estimate_speed(input sample_t s);
    logic [31:0] dt;
    longint      num;
    longint      quo;
    result_t     r;
    if (calls_since < CALLS_MAX) calls_since++;
    r.stale = 1'b0;
    if (s.time_tick != last_tick) begin
      dt  = s.time_tick - last_tick;
      num = (longint'($signed(s.position)) - longint'(last_pos)) * 2;
      quo = num / longint'({32'd0, dt});
      if (quo > SPEED_MAX) quo = SPEED_MAX;
      else if (quo < SPEED_MIN) quo = SPEED_MIN;
      speed_hold  = quo[31:0];
      last_tick   = s.time_tick;
      last_pos    = s.position;
      calls_since = 0;
    end
    if (calls_since > longint'({48'd0, limit_copy})) begin
      speed_hold = '0;
      r.stale    = 1'b1;
    end
    r.speed = speed_hold;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      limit_copy  = STALE_LIMIT_RESET;
      last_tick   = '0;
      last_pos    = '0;
      speed_hold  = '0;
      calls_since = 0;
      speed_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit_copy = cfg_data;
      if (sample_valid && sample_ready) speed_queue.push_back(estimate_speed(sample));
      if (result_valid && result_ready) begin
        if (speed_queue.size() == 0) begin
          $display("%0t: unexpected result item: speed %0d stale %0b",
                   $realtime, result.speed, result.stale);
          fail_count++;
        end else begin
          want = speed_queue.pop_front();
          if (result.speed !== want.speed || result.stale !== want.stale) begin
            $display("%0t: result mismatch: expected speed %0d stale %0b, actual speed %0d stale %0b",
                     $realtime, want.speed, want.stale, result.speed, result.stale);
            fail_count++;
          end
        end
      end
    end
    errors  <= fail_count;
    pending <= speed_queue.size();
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for the speed estimator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tse_pkg::*;

  // Cycles to wait after the last result before touching the register or ending.
  localparam int SETTLE_CYCLES = 50;
  // Long receiver hold-off so the single-item block backs up onto its input.
  localparam int HOLD_CYCLES   = 400;
  localparam int TRACK_ITEMS   = 170;
  // Repeats of one timestamp in the last run, well past the short limit used there.
  localparam int LAST_REPEATS  = 100;
  localparam int NUM_PHASES    = 9;

  logic               clk;
  logic               rst;
  logic               sample_valid;
  logic               sample_ready;
  sample_t            sample;
  logic               result_valid;
  logic               result_ready;
  result_t            result;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  int fails;
  int pending;

  // Per-phase switches for random idling on the two sides, and a one-shot
  // request for the long receiver hold-off.
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  // The track being played: current tick and position.
  logic [31:0]        cur_tick;
  logic signed [31:0] cur_pos;

  timed_speed_estimator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  tse_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (fails),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: mostly ready, with random stalls while enabled, and one long
  // hold-off on request. Every change is made at a rising edge.
  initial begin
    result_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Offers one sample item and returns at the edge that accepts it. Valid is
  // left high so a following item goes out back to back; a gap, when one is
  // taken, lowers it first.
  task automatic send_sample(input logic [31:0] tick, input logic signed [31:0] pos);
    sample_t s;
    s.time_tick = tick;
    s.position  = pos;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
  endtask

  // Drops valid and waits until every predicted result has been taken, then
  // lets the block's latency run out so that it is certainly idle.
  task automatic settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Plays a random track: each step is a new timestamp followed by a run of
  // items that repeat it. Most steps look like a real encoder (small tick and
  // position moves); the rest are full-range jumps, extreme positions, tick
  // differences close to 2^32 and plain noise. Under a limit below 20, runs of
  // repeats are sized around it so the timeout fires and just fails to fire.
  task automatic run_track(input int n_items, input int unsigned limit);
    int sent;
    int mode;
    int repeats;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        cur_tick = cur_tick + $urandom_range(1, 64);
        cur_pos  = cur_pos + $urandom_range(0, 4000) - 2000;
      end else if (mode == 6) begin
        cur_tick = cur_tick + $urandom;
        cur_pos  = $urandom;
      end else if (mode == 7) begin
        cur_tick = cur_tick + 1;
        cur_pos  = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      end else if (mode == 8) begin
        // Tick goes backwards a little: the difference wraps to nearly 2^32.
        cur_tick = cur_tick + (32'hffffffff - $urandom_range(0, 3));
        cur_pos  = cur_pos + $urandom_range(0, 200000) - 100000;
      end else begin
        cur_tick = $urandom;
        cur_pos  = cur_pos ^ $urandom;
      end
      send_sample(cur_tick, cur_pos);
      sent++;

      if (limit <= 400 && $urandom_range(0, 9) == 0) repeats = limit + 2;
      else if (limit < 20) repeats = $urandom_range(0, limit + 3);
      else repeats = $urandom_range(0, 6);
      // The position of a repeated timestamp is ignored, so it is pure noise.
      repeat (repeats) begin
        send_sample(cur_tick, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    sample_t     directed[$];
    int unsigned limits[NUM_PHASES];

    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_req     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset limit. Tick zero right after reset
    // counts as a repeated timestamp, then both saturation directions, a
    // repeat that must hold the negative extreme, a tick wrap, and quotients
    // that truncate toward zero from both sides.
    directed.push_back('{32'h00000000, 32'sh00000000});
    directed.push_back('{32'h00000000, 32'sh7fffffff});
    directed.push_back('{32'h00000001, 32'sh7fffffff});
    directed.push_back('{32'h00000002, 32'sh80000000});
    directed.push_back('{32'h00000002, 32'sh00000005});
    directed.push_back('{32'hffffffff, 32'sh00000000});
    directed.push_back('{32'h00000003, 32'sh00000064});
    directed.push_back('{32'h00000004, -32'sd1});
    directed.push_back('{32'h00000007, 32'sh00000000});
    directed.push_back('{32'h0000000a, -32'sd2});
    directed.push_back('{32'h80000000, 32'sh000003e8});
    directed.push_back('{32'h80000001, 32'sh80000000});
    directed.push_back('{32'h80000001, 32'sh7fffffff});
    foreach (directed[i]) send_sample(directed[i].time_tick, directed[i].position);
    settle();

    // With a zero limit every repeated timestamp times out at once, and a
    // fresh timestamp clears the flag again.
    write_limit('0);
    send_sample(32'd5, 32'sd12);
    send_sample(32'd5, 32'sd12);
    send_sample(32'd5, -32'sd40);
    send_sample(32'd9, 32'sd20);
    send_sample(32'd9, 32'sd20);
    cur_tick = 32'd9;
    cur_pos  = 32'sd20;
    settle();

    // Random phases over a spread of limits, the extremes among them.
    limits = '{300, 0, 1, 5, 65535, $urandom_range(0, 65535), 2,
               $urandom_range(0, 30), 300};
    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_idle_on = (p % 3) != 1;
      rx_idle_on = (p % 3) != 2;
      write_limit(LIMIT_W'(limits[p]));
      // The long hold-off lands while the sender keeps offering items.
      if (p == 1) hold_req = 1'b1;
      run_track(TRACK_ITEMS, limits[p]);
      settle();
    end

    // Last part, no idling: one back-to-back run of a single timestamp under
    // a short limit. The timeout fires on the forty-first repeat and must keep
    // firing until the run ends.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_limit(16'd40);
    cur_tick = cur_tick + 32'd17;
    send_sample(cur_tick, cur_pos);
    repeat (LAST_REPEATS) send_sample(cur_tick, $urandom);
    settle();

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
